// File: rtl/lrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_pkg: shared types and constants of the result cache
// Table depth, derived widths, command and status codes, item, result and
// entry records, and the command/status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int LRC_MAX_ENTRIES = 16;
    localparam int LRC_IDX_W = (LRC_MAX_ENTRIES > 1) ? $clog2(LRC_MAX_ENTRIES) : 1;
    localparam int LRC_CNT_W = $clog2(LRC_MAX_ENTRIES + 1);
    localparam int LRC_CAP_W = 5;
    localparam int LRC_OCC_W = 5;
    // wide enough for count + 1, capacity and the table depth
    localparam int LRC_CMP_W = (LRC_CNT_W + 1 > LRC_CAP_W) ? LRC_CNT_W + 1 : LRC_CAP_W;
    localparam logic [LRC_CAP_W-1:0] LRC_CAP_RESET = LRC_CAP_W'(16);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } lrc_cmd_code_t;

    typedef enum logic [1:0] {
        ST_COMPILED    = 2'd0,
        ST_UNSUPPORTED = 2'd1,
        ST_CANCELLED   = 2'd2,
        ST_FAILED      = 2'd3
    } lrc_status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SEARCH = 2'd1,
        S_COMMIT = 2'd2
    } lrc_state_t;

    typedef struct packed {
        lrc_cmd_code_t command;
        logic [31:0]   composition_id;
        logic [31:0]   revision;
        logic [31:0]   source_id;
        logic          has_overrides;
        lrc_status_t   compile_status;
        logic [31:0]   plan_handle;
    } lrc_item_t;

    typedef struct packed {
        logic                 hit;
        logic [31:0]          result_handle;
        logic                 stored;
        logic [31:0]          hit_count;
        logic [31:0]          compile_count;
        logic [LRC_OCC_W-1:0] occupancy;
    } lrc_result_t;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] source;
        logic [31:0] handle;
    } lrc_entry_t;

    typedef struct packed {
        logic capture;
        logic search;
        logic commit;
    } lrc_ctl_t;

    typedef struct packed {
        logic out_free;
    } lrc_stat_t;

endpackage
`default_nettype wire

// File: rtl/lrc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_ctrl: sequencer of the result cache
// Takes one item, runs the tag search, then commits the update and the result
// once the output register is free.
// ----------------------------------------------------------------------------
module lrc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire lrc_pkg::lrc_stat_t stat,
    output lrc_pkg::lrc_ctl_t      ctl
);
    import lrc_pkg::*;

    lrc_state_t state_reg;
    lrc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                state_next = S_COMMIT;
            end
            S_COMMIT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        ctl.capture = 1'b0;
        ctl.search  = 1'b0;
        ctl.commit  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                ctl.capture = s_tvalid;
            end
            S_SEARCH: begin
                ctl.search = 1'b1;
            end
            S_COMMIT: begin
                ctl.commit = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/lrc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrc_datapath: entry table, tag match, reordering and counters
// Holds the most-recently-used ordered entries in registers, matches a key
// against all of them in parallel, and applies move-to-front or insert at
// the head on commit. Owns the output register.
// ----------------------------------------------------------------------------
module lrc_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [lrc_pkg::LRC_CAP_W-1:0]     cfg_wdata,
    input  wire lrc_pkg::lrc_item_t                item_in,
    input  wire lrc_pkg::lrc_ctl_t                 ctl,
    output lrc_pkg::lrc_stat_t                     stat,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output lrc_pkg::lrc_result_t                   result
);
    import lrc_pkg::*;

    // control state
    logic [LRC_CAP_W-1:0] cap_reg;
    logic [LRC_CNT_W-1:0] count_reg;
    logic [LRC_CNT_W-1:0] count_next;
    logic [31:0]          hits_reg;
    logic [31:0]          hits_next;
    logic [31:0]          compiles_reg;
    logic [31:0]          compiles_next;
    logic                 m_valid_reg;

    // payload
    lrc_item_t            item_reg;
    logic                 found_reg;
    logic [LRC_IDX_W-1:0] pos_reg;
    lrc_entry_t           entry_reg  [LRC_MAX_ENTRIES];
    lrc_entry_t           entry_next [LRC_MAX_ENTRIES];
    lrc_result_t          out_reg;
    lrc_result_t          out_next;

    logic [LRC_MAX_ENTRIES-1:0] match;
    logic                 found_srch;
    logic [LRC_IDX_W-1:0] pos_srch;
    logic [63:0]          item_key;
    logic                 insert_ok;
    logic [LRC_CMP_W-1:0] cap_ext;
    logic [LRC_CMP_W-1:0] cap_eff;
    logic [LRC_CMP_W-1:0] grown;
    logic [LRC_CMP_W-1:0] ins_count;

    assign item_key = {item_reg.composition_id, item_reg.revision};
    assign insert_ok = !item_reg.has_overrides &&
                       (item_reg.compile_status == ST_COMPILED ||
                        item_reg.compile_status == ST_UNSUPPORTED);

    // parallel tag compare over the live part of the table
    always_comb begin
        for (int i = 0; i < LRC_MAX_ENTRIES; i++) begin
            match[i] = (entry_reg[i].key == item_key) &&
                       (entry_reg[i].source == item_reg.source_id) &&
                       (LRC_CMP_W'(i) < LRC_CMP_W'(count_reg));
        end
    end

    always_comb begin
        pos_srch = '0;
        for (int i = LRC_MAX_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                pos_srch = LRC_IDX_W'(i);
            end
        end
    end

    assign found_srch = |match;

    // occupancy after a storing insert
    always_comb begin
        cap_ext = LRC_CMP_W'(cap_reg);
        if (cap_reg == '0) begin
            cap_eff = LRC_CMP_W'(1);
        end else if (cap_ext > LRC_CMP_W'(LRC_MAX_ENTRIES)) begin
            cap_eff = LRC_CMP_W'(LRC_MAX_ENTRIES);
        end else begin
            cap_eff = cap_ext;
        end
        grown = LRC_CMP_W'(count_reg) + LRC_CMP_W'(1);
        if (grown > LRC_CMP_W'(LRC_MAX_ENTRIES)) begin
            grown = LRC_CMP_W'(LRC_MAX_ENTRIES);
        end
        ins_count = (grown > cap_eff) ? cap_eff : grown;
    end

    always_comb begin
        entry_next    = entry_reg;
        count_next    = count_reg;
        hits_next     = hits_reg;
        compiles_next = compiles_reg;
        out_next      = '0;
        case (item_reg.command)
            CMD_LOOKUP: begin
                out_next.result_handle = item_reg.plan_handle;
                if (item_reg.has_overrides || !found_reg) begin
                    compiles_next = compiles_reg + 32'd1;
                end else begin
                    // move the hit entry to the front
                    for (int i = 1; i < LRC_MAX_ENTRIES; i++) begin
                        if (LRC_IDX_W'(i) <= pos_reg) begin
                            entry_next[i] = entry_reg[i-1];
                        end
                    end
                    entry_next[0]          = entry_reg[pos_reg];
                    hits_next              = hits_reg + 32'd1;
                    out_next.hit           = 1'b1;
                    out_next.result_handle = entry_reg[pos_reg].handle;
                end
            end
            CMD_INSERT: begin
                out_next.result_handle = item_reg.plan_handle;
                if (insert_ok) begin
                    if (found_reg) begin
                        out_next.hit           = 1'b1;
                        out_next.result_handle = entry_reg[pos_reg].handle;
                    end else begin
                        for (int i = 1; i < LRC_MAX_ENTRIES; i++) begin
                            entry_next[i] = entry_reg[i-1];
                        end
                        entry_next[0].key    = item_key;
                        entry_next[0].source = item_reg.source_id;
                        entry_next[0].handle = item_reg.plan_handle;
                        count_next           = LRC_CNT_W'(ins_count);
                        out_next.stored      = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        out_next.hit_count     = hits_next;
        out_next.compile_count = compiles_next;
        out_next.occupancy     = LRC_OCC_W'(count_next);
    end

    assign stat.out_free = !m_valid_reg || m_tready;
    assign m_tvalid      = m_valid_reg;
    assign result        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg      <= LRC_CAP_RESET;
            count_reg    <= '0;
            hits_reg     <= '0;
            compiles_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (ctl.commit) begin
                count_reg    <= count_next;
                hits_reg     <= hits_next;
                compiles_reg <= compiles_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            item_reg <= item_in;
        end
        if (ctl.search) begin
            found_reg <= found_srch;
            pos_reg   <= pos_srch;
        end
        if (ctl.commit) begin
            entry_reg <= entry_next;
            out_reg   <= out_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/lru_result_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_result_cache: fully associative result cache in most-recently-used order
// Lookups move a hit to the front; inserts add absent keys at the front and
// drop the tail beyond the capacity; clear empties the table.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | contents
//  s_       | in        | s_tvalid / s_tready | request item, command in s_tuser
//  m_       | out       | m_tvalid / m_tready | result item
//  cfg_     | in        | cfg_we              | capacity register
//
//  An item passes capture, tag search over all entries in parallel,
//  and commit of the table update with the result into the output register.
//  A new item is taken while the previous result still waits on m_tready;
//  commit waits only while that result has not been taken.
//  Reset is synchronous: table empty, counters zero, capacity 16.
//  No clearing pass is needed.
// ----------------------------------------------------------------------------
module lru_result_cache (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_we,
    input  wire logic [4:0]    cfg_wdata,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // composition_id, revision, source_id, has_overrides, compile_status,
    // plan_handle, zero pad
    input  wire logic [135:0]  s_tdata,
    // command
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // hit, result_handle, stored, hit_count, compile_count, occupancy, zero pad
    output logic [103:0]       m_tdata
);
    import lrc_pkg::*;

    lrc_item_t   item_in;
    lrc_result_t result;
    lrc_ctl_t    ctl;
    lrc_stat_t   stat;

    assign item_in.command        = lrc_cmd_code_t'(s_tuser);
    assign item_in.composition_id = s_tdata[31:0];
    assign item_in.revision       = s_tdata[63:32];
    assign item_in.source_id      = s_tdata[95:64];
    assign item_in.has_overrides  = s_tdata[96];
    assign item_in.compile_status = lrc_status_t'(s_tdata[98:97]);
    assign item_in.plan_handle    = s_tdata[130:99];

    assign m_tdata = {1'b0, result.occupancy, result.compile_count, result.hit_count,
                      result.stored, result.result_handle, result.hit};

    lrc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    lrc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_in   (item_in),
        .ctl       (ctl),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .result    (result)
    );

    // one item in flight: no new item right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while another is in flight");

    // a result is never both a hit and a new entry
    a_hit_or_stored: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[33]))
        else $error("result reports hit and stored together");

    // occupancy stays within the table depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[102:98] <= LRC_OCC_W'(LRC_MAX_ENTRIES)))
        else $error("occupancy beyond table depth");

    // a stored entry always leaves at least one valid entry
    a_stored_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33]) |-> (m_tdata[102:98] != '0))
        else $error("stored result with empty table");

endmodule
`default_nettype wire

// File: test/lru_result_cache_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_result_cache_tb: self-checking bench for the result cache
// Drives lookups, inserts, clears and no-ops over a pool of related keys.
// A mirror of the table in move-to-front order predicts every result item,
// and the bench steps through several capacity settings, the out-of-range
// ones among them. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lru_result_cache_tb;
    import lrc_pkg::*;

    localparam int KEY_POOL = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES = 7;

    // mirror of the table contents and counters, plus the results still owed
    class cache_mirror;
        lrc_entry_t slots[LRC_MAX_ENTRIES];
        int unsigned used;
        logic [31:0] hits;
        logic [31:0] compiles;
        logic [LRC_CAP_W-1:0] cap_reg;
        lrc_result_t expected_results[$];
        int unsigned mismatches;
        int unsigned checked;

        function new();
            used = 0;
            hits = '0;
            compiles = '0;
            cap_reg = LRC_CAP_RESET;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_capacity(logic [LRC_CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        function int unsigned outstanding();
            return expected_results.size();
        endfunction

        function int unsigned kept_limit();
            if (cap_reg == 0) return 1;
            if (cap_reg > LRC_MAX_ENTRIES) return LRC_MAX_ENTRIES;
            return cap_reg;
        endfunction

        // index of the matching entry, or used when absent
        function int unsigned locate(logic [63:0] key, logic [31:0] src);
            int unsigned i;
            for (i = 0; i < used && i < LRC_MAX_ENTRIES; i++) begin
                if (slots[i].key == key && slots[i].source == src) return i;
            end
            return used;
        endfunction

        function void note_request(lrc_item_t it);
            lrc_result_t r;
            lrc_entry_t e;
            logic [63:0] key;
            int unsigned pos;
            int unsigned n;
            int unsigned i;
            key = {it.composition_id, it.revision};
            r = '0;
            case (it.command)
                CMD_LOOKUP: begin
                    r.result_handle = it.plan_handle;
                    if (it.has_overrides) begin
                        compiles++;
                    end else begin
                        pos = locate(key, it.source_id);
                        if (pos < used) begin
                            e = slots[pos];
                            for (i = pos; i > 0; i--) slots[i] = slots[i-1];
                            slots[0] = e;
                            hits++;
                            r.hit = 1'b1;
                            r.result_handle = e.handle;
                        end else begin
                            compiles++;
                        end
                    end
                end
                CMD_INSERT: begin
                    r.result_handle = it.plan_handle;
                    if (!it.has_overrides &&
                        (it.compile_status == ST_COMPILED ||
                         it.compile_status == ST_UNSUPPORTED)) begin
                        pos = locate(key, it.source_id);
                        if (pos < used) begin
                            // existing key: report its handle, no reordering
                            r.hit = 1'b1;
                            r.result_handle = slots[pos].handle;
                        end else begin
                            n = (used + 1 > LRC_MAX_ENTRIES) ? LRC_MAX_ENTRIES : used + 1;
                            for (i = n - 1; i > 0; i--) slots[i] = slots[i-1];
                            slots[0].key = key;
                            slots[0].source = it.source_id;
                            slots[0].handle = it.plan_handle;
                            // also trims entries left over from a larger capacity
                            used = (n > kept_limit()) ? kept_limit() : n;
                            r.stored = 1'b1;
                        end
                    end
                end
                CMD_CLEAR: begin
                    used = 0;
                end
                default: begin
                end
            endcase
            r.hit_count = hits;
            r.compile_count = compiles;
            r.occupancy = used[LRC_OCC_W-1:0];
            expected_results.push_back(r);
        endfunction

        function void check_response(logic [103:0] raw);
            lrc_result_t got;
            lrc_result_t want;
            bit bad;
            got.hit = raw[0];
            got.result_handle = raw[32:1];
            got.stored = raw[33];
            got.hit_count = raw[65:34];
            got.compile_count = raw[97:66];
            got.occupancy = raw[102:98];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: hit=%0b handle=%h occ=%0d",
                             got.hit, got.result_handle, got.occupancy);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            bad = 1'b0;
            if (got.hit !== want.hit) bad = 1'b1;
            if (got.result_handle !== want.result_handle) bad = 1'b1;
            if (got.stored !== want.stored) bad = 1'b1;
            if (got.hit_count !== want.hit_count) bad = 1'b1;
            if (got.compile_count !== want.compile_count) bad = 1'b1;
            if (got.occupancy !== want.occupancy) bad = 1'b1;
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d", checked);
                    $display("  exp hit=%0b handle=%h stored=%0b hits=%0d compiles=%0d occ=%0d",
                             want.hit, want.result_handle, want.stored,
                             want.hit_count, want.compile_count, want.occupancy);
                    $display("  got hit=%0b handle=%h stored=%0b hits=%0d compiles=%0d occ=%0d",
                             got.hit, got.result_handle, got.stored,
                             got.hit_count, got.compile_count, got.occupancy);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [4:0] cfg_wdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [103:0] m_tdata;

    cache_mirror mirror = new();
    int unsigned idle_pct = 13;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    logic [31:0] pool_comp[KEY_POOL];
    logic [31:0] pool_rev[KEY_POOL];
    logic [31:0] pool_src[KEY_POOL];

    lru_result_cache i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycles, mirror.outstanding());
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: check accepted items, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) mirror.check_response(m_tdata);
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    function automatic lrc_item_t make_item(lrc_cmd_code_t cmd, logic [31:0] comp,
                                            logic [31:0] rev, logic [31:0] src,
                                            logic ovr, lrc_status_t st,
                                            logic [31:0] handle);
        lrc_item_t it;
        it.command = cmd;
        it.composition_id = comp;
        it.revision = rev;
        it.source_id = src;
        it.has_overrides = ovr;
        it.compile_status = st;
        it.plan_handle = handle;
        return it;
    endfunction

    function automatic lrc_item_t random_request();
        lrc_item_t it;
        int unsigned roll;
        int unsigned sel;
        roll = $urandom_range(0, 99);
        if (roll < 47) it.command = CMD_LOOKUP;
        else if (roll < 95) it.command = CMD_INSERT;
        else if (roll < 97) it.command = CMD_CLEAR;
        else it.command = CMD_NOP;
        if ($urandom_range(0, 99) < 85) begin
            sel = $urandom_range(0, KEY_POOL - 1);
            it.composition_id = pool_comp[sel];
            it.revision = pool_rev[sel];
            it.source_id = pool_src[sel];
        end else begin
            it.composition_id = $urandom;
            it.revision = $urandom;
            it.source_id = $urandom;
        end
        it.has_overrides = ($urandom_range(0, 99) < 12);
        roll = $urandom_range(0, 99);
        if (roll < 55) it.compile_status = ST_COMPILED;
        else if (roll < 75) it.compile_status = ST_UNSUPPORTED;
        else if (roll < 88) it.compile_status = ST_CANCELLED;
        else it.compile_status = ST_FAILED;
        it.plan_handle = $urandom;
        return it;
    endfunction

    task automatic send_request(input lrc_item_t it);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, it.plan_handle, it.compile_status, it.has_overrides,
                    it.source_id, it.revision, it.composition_id};
        s_tuser <= it.command;
        do @(posedge aclk); while (!s_tready);
        mirror.note_request(it);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (mirror.outstanding() != 0) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mirror.set_capacity(value);
    endtask

    initial begin
        logic [4:0] phase_cap[NUM_PHASES];
        int unsigned phase_items[NUM_PHASES];
        int unsigned p;
        int unsigned k;
        phase_cap = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd17, 5'd9};
        phase_items = '{120, 70, 60, 90, 50, 80, 80};
        // neighbors share composition id or revision so the compare is exercised per field
        for (k = 0; k < KEY_POOL; k++) begin
            pool_comp[k] = (k % 4 != 0) ? pool_comp[k-1] : $urandom;
            pool_rev[k] = (k % 4 >= 2) ? pool_rev[k-1] : $urandom;
            pool_src[k] = (k % 4 == 3) ? $urandom : ((k % 4 == 2) ? ~pool_src[k-1] : $urandom);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extreme keys, every insert outcome, bypass, no-op
        send_request(make_item(CMD_LOOKUP, '0, '0, '0, 1'b0, ST_COMPILED, 32'h1234_5678));
        send_request(make_item(CMD_INSERT, '0, '0, '0, 1'b0, ST_COMPILED, '0));
        send_request(make_item(CMD_LOOKUP, '0, '0, '0, 1'b0, ST_COMPILED, '1));
        send_request(make_item(CMD_INSERT, '1, '1, '1, 1'b0, ST_UNSUPPORTED, '1));
        send_request(make_item(CMD_INSERT, '1, '1, '1, 1'b0, ST_COMPILED, 32'h0bad_f00d));
        send_request(make_item(CMD_INSERT, '1, '0, '1, 1'b0, ST_CANCELLED, 32'h5555_aaaa));
        send_request(make_item(CMD_INSERT, '1, '0, '1, 1'b0, ST_FAILED, 32'haaaa_5555));
        send_request(make_item(CMD_INSERT, '0, '1, '0, 1'b1, ST_COMPILED, 32'h0000_ffff));
        send_request(make_item(CMD_LOOKUP, '1, '1, '1, 1'b1, ST_FAILED, 32'hffff_0000));
        send_request(make_item(CMD_LOOKUP, '1, '1, '1, 1'b0, ST_CANCELLED, '0));
        send_request(make_item(CMD_NOP, '1, '1, '1, 1'b1, ST_FAILED, '1));
        send_request(make_item(CMD_LOOKUP, '0, '0, '1, 1'b0, ST_COMPILED, 32'h0f0f_0f0f));
        send_request(make_item(CMD_LOOKUP, '0, '0, '0, 1'b0, ST_COMPILED, 32'hf0f0_f0f0));
        send_request(make_item(CMD_CLEAR, '1, '1, '1, 1'b1, ST_FAILED, '1));

        // random phases, each under its own capacity
        for (p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) write_capacity(phase_cap[p]);
            idle_pct = (p == 3) ? 0 : 13;
            for (k = 0; k < phase_items[p]; k++) send_request(random_request());
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("sent %0d items, checked %0d results, %0d table hits, %0d compiles",
                 items_sent, mirror.checked, mirror.hits, mirror.compiles);
        $display("capacities walked: reset 16, then 4, 0, 31, 1, 17, 9; mismatches %0d",
                 mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
